[src/sstd_pkg.sv]
// Shared types, sizes and codes for the sorted score table.
package sstd_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NAME_W = 24;
    localparam int SCORE_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W = 5;

    typedef logic [NAME_W-1:0] name_t;
    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_IGNORED  = 3'd1;
    localparam status_t ST_UPDATED  = 3'd2;
    localparam status_t ST_REMOVED  = 3'd3;
    localparam status_t ST_EMPTY    = 3'd4;
    localparam status_t ST_REFUSED  = 3'd5;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_DELETE,
        TBL_INSERT
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        idx_t    idx;
        name_t   name;
        score_t  score;
    } tbl_cmd_t;

    typedef struct packed {
        logic name_eq;
        logic stored_gt;
        logic new_before;
    } cmp_res_t;

endpackage

[src/sstd_cmp.sv]
// Shared compare unit: name match, score order and rank order of two entries.
module sstd_cmp (
    input  sstd_pkg::name_t    new_name,
    input  sstd_pkg::score_t   new_score,
    input  sstd_pkg::name_t    stored_name,
    input  sstd_pkg::score_t   stored_score,
    output sstd_pkg::cmp_res_t res
);
    import sstd_pkg::*;

    always_comb begin
        res.name_eq    = (new_name == stored_name);
        res.stored_gt  = (stored_score > new_score);
        res.new_before = (new_score > stored_score) ||
                         ((new_score == stored_score) && (new_name < stored_name));
    end

endmodule

[src/sstd_table.sv]
// Entry register file with parallel shift for delete and ordered insert.
module sstd_table (
    input  logic              aclk,
    input  sstd_pkg::tbl_cmd_t cmd,
    input  sstd_pkg::idx_t    rd_idx,
    output sstd_pkg::name_t   rd_name,
    output sstd_pkg::score_t  rd_score,
    output sstd_pkg::name_t   head_name,
    output sstd_pkg::score_t  head_score
);
    import sstd_pkg::*;

    name_t  name_reg  [DEPTH];
    score_t score_reg [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        always_ff @(posedge aclk) begin
            case (cmd.op)
                TBL_DELETE: begin
                    if (idx_t'(i) >= cmd.idx) begin
                        if (i < DEPTH - 1) begin
                            name_reg[i]  <= name_reg[(i < DEPTH - 1) ? i + 1 : i];
                            score_reg[i] <= score_reg[(i < DEPTH - 1) ? i + 1 : i];
                        end
                    end
                end
                TBL_INSERT: begin
                    if (idx_t'(i) == cmd.idx) begin
                        name_reg[i]  <= cmd.name;
                        score_reg[i] <= cmd.score;
                    end else if (idx_t'(i) > cmd.idx) begin
                        name_reg[i]  <= name_reg[(i > 0) ? i - 1 : i];
                        score_reg[i] <= score_reg[(i > 0) ? i - 1 : i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_name    = name_reg[rd_idx];
    assign rd_score   = score_reg[rd_idx];
    assign head_name  = name_reg[0];
    assign head_score = score_reg[0];

endmodule

[src/sorted_score_table_with_name_dedupe.sv]
// Sorted score table with name dedupe: sequencer, entry count and result register.
// Remove: the head entry, if any, is deleted and returned. Add: a name walk, a full check
// if the name is new and the table full, then an ordered-position walk to the insert, if any.
// Next accept in the cycle after the result loads; a held result stalls the sequencer.
// Reset (aresetn low, synchronous) empties the table and clears the result channel.
// Entry storage has no reset; only entries below the count are ever read.
module sorted_score_table_with_name_dedupe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  sstd_pkg::name_t     s_entry_name,
    input  sstd_pkg::score_t    s_entry_score,
    output logic                m_valid,
    input  logic                m_ready,
    output sstd_pkg::status_t   m_status,
    output sstd_pkg::name_t     m_head_name,
    output sstd_pkg::score_t    m_head_score,
    output sstd_pkg::count_t    m_entry_count
);
    import sstd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_FIND,
        S_FULL,
        S_SEEK,
        S_DONE
    } state_t;

    state_t   state_reg;
    name_t    name_reg;
    score_t   score_reg;
    cnt_t     count_reg;
    cnt_t     walk_reg;
    status_t  status_reg;
    name_t    head_name_reg;
    score_t   head_score_reg;
    logic     m_valid_reg;
    status_t  m_status_reg;
    name_t    m_head_name_reg;
    score_t   m_head_score_reg;
    count_t   m_count_reg;

    tbl_cmd_t tbl_cmd;
    name_t    rd_name;
    score_t   rd_score;
    name_t    head_name;
    score_t   head_score;
    cmp_res_t cmp;

    sstd_table u_table (
        .aclk       (aclk),
        .cmd        (tbl_cmd),
        .rd_idx     (walk_reg[IDX_W-1:0]),
        .rd_name    (rd_name),
        .rd_score   (rd_score),
        .head_name  (head_name),
        .head_score (head_score)
    );

    sstd_cmp u_cmp (
        .new_name     (name_reg),
        .new_score    (score_reg),
        .stored_name  (rd_name),
        .stored_score (rd_score),
        .res          (cmp)
    );

    always_comb begin
        tbl_cmd       = '0;
        tbl_cmd.op    = TBL_NOP;
        tbl_cmd.idx   = walk_reg[IDX_W-1:0];
        tbl_cmd.name  = name_reg;
        tbl_cmd.score = score_reg;
        case (state_reg)
            S_REMOVE: begin
                if (count_reg != '0) begin
                    tbl_cmd.op  = TBL_DELETE;
                    tbl_cmd.idx = '0;
                end
            end
            S_FIND: begin
                if (walk_reg != count_reg && cmp.name_eq && !cmp.stored_gt) begin
                    tbl_cmd.op = TBL_DELETE;
                end
            end
            S_SEEK: begin
                if (walk_reg == count_reg || cmp.new_before) begin
                    tbl_cmd.op = TBL_INSERT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        name_reg       <= s_entry_name;
                        score_reg      <= s_entry_score;
                        head_name_reg  <= '0;
                        head_score_reg <= '0;
                        walk_reg       <= '0;
                        state_reg      <= (s_operation == OP_REMOVE) ? S_REMOVE : S_FIND;
                    end
                end
                S_REMOVE: begin
                    if (count_reg == '0) begin
                        status_reg <= ST_EMPTY;
                    end else begin
                        head_name_reg  <= head_name;
                        head_score_reg <= head_score;
                        count_reg      <= count_reg - 1'b1;
                        status_reg     <= ST_REMOVED;
                    end
                    state_reg <= S_DONE;
                end
                S_FIND: begin
                    if (walk_reg == count_reg) begin
                        if (count_reg == cnt_t'(DEPTH)) begin
                            walk_reg  <= count_reg - 1'b1;
                            state_reg <= S_FULL;
                        end else begin
                            walk_reg   <= '0;
                            status_reg <= ST_INSERTED;
                            state_reg  <= S_SEEK;
                        end
                    end else if (cmp.name_eq) begin
                        if (cmp.stored_gt) begin
                            status_reg <= ST_IGNORED;
                            state_reg  <= S_DONE;
                        end else begin
                            count_reg  <= count_reg - 1'b1;
                            walk_reg   <= '0;
                            status_reg <= ST_UPDATED;
                            state_reg  <= S_SEEK;
                        end
                    end else begin
                        walk_reg <= walk_reg + 1'b1;
                    end
                end
                S_FULL: begin
                    if (cmp.new_before) begin
                        count_reg  <= count_reg - 1'b1;
                        walk_reg   <= '0;
                        status_reg <= ST_INSERTED;
                        state_reg  <= S_SEEK;
                    end else begin
                        status_reg <= ST_REFUSED;
                        state_reg  <= S_DONE;
                    end
                end
                S_SEEK: begin
                    if (walk_reg == count_reg || cmp.new_before) begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        walk_reg <= walk_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= status_reg;
                        m_head_name_reg  <= head_name_reg;
                        m_head_score_reg <= head_score_reg;
                        m_count_reg      <= count_t'(count_reg);
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_head_name   = m_head_name_reg;
    assign m_head_score  = m_head_score_reg;
    assign m_entry_count = m_count_reg;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the sorted score table with name dedupe.
`timescale 1ns / 1ps

module tb_top;
    import sstd_pkg::*;

    localparam int N_RANDOM = 1550;
    localparam int MAX_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int POOL_SIZE = 24;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic   op;
        name_t  name;
        score_t score;
    } table_txn_t;

    typedef struct packed {
        status_t status;
        name_t   head_name;
        score_t  head_score;
        count_t  entry_count;
    } table_result_t;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    logic    s_operation = OP_ADD;
    name_t   s_entry_name = '0;
    score_t  s_entry_score = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    status_t m_status;
    name_t   m_head_name;
    score_t  m_head_score;
    count_t  m_entry_count;

    table_txn_t    txn_q[$];
    table_result_t result_q[$];
    name_t         name_pool[POOL_SIZE];

    score_t tbl_score[DEPTH];
    name_t  tbl_name[DEPTH];
    int     tbl_fill = 0;
    int     peak_fill = 0;

    int cycle_cnt = 0;
    int fail_cnt = 0;
    int n_results = 0;
    int status_hits[6] = '{default: 0};
    int tx_wait = 0;
    int rx_wait = 0;
    int rx_gap;
    logic quiet;

    table_txn_t    cur_txn;
    table_result_t exp_res;

    sorted_score_table_with_name_dedupe u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_name  (s_entry_name),
        .s_entry_score (s_entry_score),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_head_name   (m_head_name),
        .m_head_score  (m_head_score),
        .m_entry_count (m_entry_count)
    );

    always #10 aclk = ~aclk;

    assign quiet = ((cycle_cnt / 2000) % 4) == 3;

    function automatic bit ranks_ahead(score_t s1, name_t n1, score_t s2, name_t n2);
        if (s1 != s2) return s1 > s2;
        return n1 < n2;
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < tbl_fill; i++) begin
            tbl_score[i] = tbl_score[i + 1];
            tbl_name[i] = tbl_name[i + 1];
        end
        tbl_fill--;
    endfunction

    function automatic void insert_ordered(score_t score, name_t name);
        int pos;
        pos = 0;
        while (pos < tbl_fill && !ranks_ahead(score, name, tbl_score[pos], tbl_name[pos]))
            pos++;
        for (int i = tbl_fill; i > pos; i--) begin
            tbl_score[i] = tbl_score[i - 1];
            tbl_name[i] = tbl_name[i - 1];
        end
        tbl_score[pos] = score;
        tbl_name[pos] = name;
        tbl_fill++;
    endfunction

    function automatic table_result_t update_table(logic op, name_t name, score_t score);
        table_result_t res;
        int found;
        res = '0;
        if (op == OP_REMOVE) begin
            if (tbl_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.head_name = tbl_name[0];
                res.head_score = tbl_score[0];
                drop_entry(0);
                res.status = ST_REMOVED;
            end
        end else begin
            found = -1;
            for (int i = 0; i < tbl_fill; i++) begin
                if (found < 0 && tbl_name[i] == name) found = i;
            end
            if (found >= 0) begin
                if (tbl_score[found] > score) begin
                    res.status = ST_IGNORED;
                end else begin
                    drop_entry(found);
                    insert_ordered(score, name);
                    res.status = ST_UPDATED;
                end
            end else if (tbl_fill >= DEPTH) begin
                if (!ranks_ahead(score, name, tbl_score[tbl_fill - 1],
                                 tbl_name[tbl_fill - 1])) begin
                    res.status = ST_REFUSED;
                end else begin
                    tbl_fill--;
                    insert_ordered(score, name);
                    res.status = ST_INSERTED;
                end
            end else begin
                insert_ordered(score, name);
                res.status = ST_INSERTED;
            end
        end
        res.entry_count = count_t'(tbl_fill);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic name_t pick_name();
        if ($urandom_range(0, 9) < 7) return name_pool[$urandom_range(0, POOL_SIZE - 1)];
        return name_t'($urandom);
    endfunction

    function automatic score_t pick_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return score_t'($urandom_range(0, 16)) - 8;
        if (r < 60) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7fff_ffff;
                3: return 32'sh7fff_fffe;
                4: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return score_t'($urandom);
    endfunction

    function automatic void add_txn(logic op, name_t name, score_t score);
        table_txn_t t;
        t.op = op;
        t.name = name;
        t.score = score;
        txn_q.push_back(t);
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("sorted_score_table_with_name_dedupe test failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                result_q.push_back(update_table(s_operation, s_entry_name, s_entry_score));
                if (tbl_fill > peak_fill) peak_fill = tbl_fill;
            end
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait <= tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (txn_q.size() > 0) begin
                    cur_txn = txn_q.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= cur_txn.op;
                    s_entry_name <= cur_txn.name;
                    s_entry_score <= cur_txn.score;
                    tx_wait <= quiet ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("unexpected result: status=%0d head=%06h/%0d count=%0d",
                                 m_status, m_head_name, m_head_score, m_entry_count);
                end else begin
                    exp_res = result_q.pop_front();
                    status_hits[exp_res.status]++;
                    if (m_status !== exp_res.status || m_head_name !== exp_res.head_name ||
                        m_head_score !== exp_res.head_score ||
                        m_entry_count !== exp_res.entry_count) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"mismatch at result %0d: ",
                                      "exp status=%0d head=%06h/%0d count=%0d, ",
                                      "got status=%0d head=%06h/%0d count=%0d"},
                                     n_results, exp_res.status, exp_res.head_name,
                                     exp_res.head_score, exp_res.entry_count, m_status,
                                     m_head_name, m_head_score, m_entry_count);
                    end
                end
            end
            if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= 1'b0;
            end else if (!quiet && ((m_valid && m_ready) || $urandom_range(0, 15) == 0)) begin
                rx_gap = pick_gap();
                if (rx_gap > 0) begin
                    m_ready <= 1'b0;
                    rx_wait <= rx_gap - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int phase;
        int phase_left;
        int add_pct;

        name_pool[0] = 24'h000000;
        name_pool[1] = 24'hffffff;
        for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = name_t'($urandom);

        // empty remove, extreme fields, dedupe rules, score ties
        add_txn(OP_REMOVE, 24'hffffff, 32'sh7fff_ffff);
        add_txn(OP_ADD, 24'h000000, 32'sh8000_0000);
        add_txn(OP_ADD, 24'hffffff, 32'sh7fff_ffff);
        add_txn(OP_ADD, 24'h414243, 32'sd0);
        add_txn(OP_ADD, 24'h414243, 32'sd0);
        add_txn(OP_ADD, 24'h414243, -32'sd5);
        add_txn(OP_ADD, 24'h414243, 32'sd100);
        add_txn(OP_ADD, 24'h414244, 32'sd100);
        add_txn(OP_ADD, 24'h414242, 32'sd100);
        // fill to capacity
        for (int i = 0; i < DEPTH - 5; i++)
            add_txn(OP_ADD, 24'h4b0000 + name_t'(i), score_t'(i * 7) - 20);
        // full table: refuse a lower rank, then evict the lowest
        add_txn(OP_ADD, 24'h000001, 32'sh8000_0000);
        add_txn(OP_ADD, 24'h505152, 32'sd50);
        add_txn(OP_REMOVE, 24'h000000, 32'sh0000_0000);
        add_txn(OP_REMOVE, 24'h123456, -32'sd1);
        add_txn(OP_REMOVE, 24'hffffff, 32'sh8000_0000);

        phase = 0;
        phase_left = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 2);
                phase_left = $urandom_range(30, 120);
            end
            phase_left--;
            case (phase)
                0: add_pct = 85;
                1: add_pct = 30;
                default: add_pct = 60;
            endcase
            if ($urandom_range(0, 99) < add_pct)
                add_txn(OP_ADD, pick_name(), pick_score());
            else
                add_txn(OP_REMOVE, name_t'($urandom), score_t'($urandom));
        end

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (txn_q.size() != 0 || s_valid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (result_q.size() != 0) begin
            fail_cnt += result_q.size();
            $display("%0d results never arrived", result_q.size());
        end
        if (fail_cnt > MAX_REPORTS)
            $display("%0d further mismatches not shown", fail_cnt - MAX_REPORTS);

        $display({"covered %0d transactions: %0d inserted, %0d ignored, %0d updated, ",
                  "%0d removed, %0d empty, %0d refused"},
                 n_results, status_hits[ST_INSERTED], status_hits[ST_IGNORED],
                 status_hits[ST_UPDATED], status_hits[ST_REMOVED], status_hits[ST_EMPTY],
                 status_hits[ST_REFUSED]);
        $display("peak table fill %0d of %0d, %0d cycles", peak_fill, DEPTH, cycle_cnt);

        if (fail_cnt == 0)
            $display("sorted_score_table_with_name_dedupe test passed");
        else
            $display("sorted_score_table_with_name_dedupe test failed");
        $finish;
    end

endmodule
